@@ hdl/fdl_pkg.sv @@
// Shared constants for the frame difference luma block.
package fdl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DELAY_FRAMES = 2'd0;
    localparam logic [1:0] CFG_GAIN_Q8      = 2'd1;
    localparam logic [1:0] CFG_FRAME_PIXELS = 2'd2;

    // Rec.601 luma weights, scaled by 1000
    localparam logic [9:0] WEIGHT_RED   = 10'd299;
    localparam logic [9:0] WEIGHT_GREEN = 10'd587;
    localparam logic [9:0] WEIGHT_BLUE  = 10'd114;

    // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums below 2^18
    localparam logic [18:0] RECIP_1000 = 19'd268436;
    localparam int          DIV_SHIFT  = 28;

    // Rounding offset for the 9.8 gain
    localparam logic [7:0] GAIN_ROUND = 8'd128;

    // Saturation limit of the grey output
    localparam logic [7:0] GREY_MAX = 8'd255;

    // Reset values of the configuration registers
    localparam logic [16:0] GAIN_RESET  = 17'd256;
    localparam int          FRAME_RESET = 4096;

endpackage

@@ hdl/frame_difference_luma.sv @@
// Frame difference luma: pixel store ring, absolute difference, luma and gain pipeline.
//
// Takes one RGB pixel per clock and returns one grey pixel per clock while the output
// is not stalled: the gained Rec.601 luma of the absolute difference between the pixel
// and the pixel at the same position delay_frames frames earlier. The sustained rate
// is one transaction per cycle while out_ready stays high; the input reaches the output
// register through seven pipeline stages (address, store read, weighting, sum, divide
// by 1000, gain, saturation). The whole pipeline holds when the output is stalled.
// After reset the pixel store (DELAY_SLOTS x MAX_FRAME_PIXELS entries, one write port)
// is cleared one entry per cycle, and no pixel is taken until that pass ends;
// configuration writes are taken at any time and are to be issued only while no pixel
// is in flight.
module frame_difference_luma
    import fdl_pkg::*;
#(
    parameter int DELAY_SLOTS      = 8,
    parameter int MAX_FRAME_PIXELS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  grey,
    output logic        frame_end,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int SW      = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
    localparam int PW      = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int LW      = (PW + 1 > 13) ? PW + 1 : 13;
    localparam int DEPTH   = DELAY_SLOTS * MAX_FRAME_PIXELS;
    localparam int AW      = $clog2(DEPTH);
    localparam int LEN_RST = (MAX_FRAME_PIXELS < FRAME_RESET) ? MAX_FRAME_PIXELS : FRAME_RESET;

    // Reduce a 3-bit delay modulo the slot count
    function automatic logic [SW-1:0] slot_mod(input logic [2:0] v);
        logic [6:0] t;
        t = {4'd0, v};
        for (int i = 0; i < 4; i++) begin
            if (t >= 7'(DELAY_SLOTS)) begin
                t = t - 7'(DELAY_SLOTS);
            end
        end
        return t[SW-1:0];
    endfunction

    // configuration
    logic [SW-1:0] delay_reg;
    logic [16:0]   gain_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] fp_ext;

    // frame position and store clearing
    logic [SW-1:0] wslot_reg;
    logic [SW-1:0] wslot_next;
    logic [PW-1:0] pix_reg;
    logic [PW-1:0] pix_next;
    logic [LW-1:0] pos_inc;
    logic          is_end;
    logic [SW:0]   rslot_sum;
    logic [SW-1:0] rslot;
    logic          clearing_reg;
    logic [AW-1:0] clr_reg;

    // handshake
    logic adv;
    logic in_fire;

    // stage 1: addresses
    logic          s1_valid_reg;
    logic [AW-1:0] s1_waddr_reg;
    logic [AW-1:0] s1_raddr_reg;
    logic [23:0]   s1_cur_reg;
    logic          s1_dzero_reg;
    logic          s1_end_reg;

    // stage 2: store read
    logic [23:0]   mem [DEPTH];
    logic          s2_valid_reg;
    logic [23:0]   s2_rd_reg;
    logic [23:0]   s2_cur_reg;
    logic          s2_dzero_reg;
    logic          s2_end_reg;

    // stage 3: weighted channel differences
    logic [23:0]   ref_pix;
    logic [7:0]    dr;
    logic [7:0]    dg;
    logic [7:0]    db;
    logic          s3_valid_reg;
    logic [16:0]   s3_pr_reg;
    logic [17:0]   s3_pg_reg;
    logic [14:0]   s3_pb_reg;
    logic          s3_end_reg;

    // stage 4: weighted sum
    logic          s4_valid_reg;
    logic [17:0]   s4_sum_reg;
    logic          s4_end_reg;

    // stage 5: divide by 1000
    logic [36:0]   div_prod;
    logic [8:0]    luma_wide;
    logic          s5_valid_reg;
    logic [7:0]    s5_luma_reg;
    logic          s5_end_reg;

    // stage 6: gain
    logic          s6_valid_reg;
    logic [24:0]   s6_scaled_reg;
    logic          s6_end_reg;

    // output register
    logic [16:0]   grey_wide;
    logic          out_valid_reg;
    logic [7:0]    grey_reg;
    logic          frame_end_reg;

    // Hold the whole pipeline while the output transaction waits
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv && !clearing_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Clamp the written frame length to 1 .. MAX_FRAME_PIXELS
    always_comb
    begin
        fp_ext = LW'(cfg_data[12:0]);
        if (fp_ext == '0) begin
            len_next = LW'(1);
        end else if (fp_ext > LW'(MAX_FRAME_PIXELS)) begin
            len_next = LW'(MAX_FRAME_PIXELS);
        end else begin
            len_next = fp_ext;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            delay_reg <= SW'(1);
            gain_reg  <= GAIN_RESET;
            len_reg   <= LW'(LEN_RST);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELAY_FRAMES: delay_reg <= slot_mod(cfg_data[2:0]);
                CFG_GAIN_Q8:      gain_reg  <= cfg_data;
                CFG_FRAME_PIXELS: len_reg   <= len_next;
                default:          ;
            endcase
        end
    end

    // Frame position, next write slot and reference slot
    always_comb
    begin
        pos_inc = LW'(pix_reg) + LW'(1);
        is_end  = (pos_inc >= len_reg);
        if (is_end) begin
            pix_next = '0;
        end else begin
            pix_next = pos_inc[PW-1:0];
        end
        if ({1'b0, wslot_reg} == (SW+1)'(DELAY_SLOTS - 1)) begin
            wslot_next = '0;
        end else begin
            wslot_next = wslot_reg + SW'(1);
        end
        rslot_sum = {1'b0, wslot_reg} + (SW+1)'(DELAY_SLOTS) - {1'b0, delay_reg};
        if (rslot_sum >= (SW+1)'(DELAY_SLOTS)) begin
            rslot = SW'(rslot_sum - (SW+1)'(DELAY_SLOTS));
        end else begin
            rslot = rslot_sum[SW-1:0];
        end
    end

    // Advance frame position on each accepted pixel; sweep the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wslot_reg    <= '0;
            pix_reg      <= '0;
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end else begin
            if (in_fire) begin
                pix_reg <= pix_next;
                if (is_end) begin
                    wslot_reg <= wslot_next;
                end
            end
            if (clearing_reg) begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // Stage 1 payload: store addresses and pixel
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_waddr_reg <= AW'(wslot_reg) * AW'(MAX_FRAME_PIXELS) + AW'(pix_reg);
            s1_raddr_reg <= AW'(rslot) * AW'(MAX_FRAME_PIXELS) + AW'(pix_reg);
            s1_cur_reg   <= {red, green, blue};
            s1_dzero_reg <= (delay_reg == '0);
            s1_end_reg   <= is_end;
        end
    end

    // Pixel store: clear pass, then one write and one read per advancing transaction
    always_ff @(posedge clk)
    begin
        if (clearing_reg) begin
            mem[clr_reg] <= '0;
        end else if (adv && s1_valid_reg) begin
            mem[s1_waddr_reg] <= s1_cur_reg;
        end
        if (adv) begin
            s2_rd_reg <= mem[s1_raddr_reg];
        end
    end

    // Absolute channel differences against the reference pixel; divide and gain scaling terms
    always_comb
    begin
        ref_pix = s2_dzero_reg ? s2_cur_reg : s2_rd_reg;
        dr = (s2_cur_reg[23:16] > ref_pix[23:16]) ? s2_cur_reg[23:16] - ref_pix[23:16]
                                                  : ref_pix[23:16] - s2_cur_reg[23:16];
        dg = (s2_cur_reg[15:8] > ref_pix[15:8]) ? s2_cur_reg[15:8] - ref_pix[15:8]
                                                : ref_pix[15:8] - s2_cur_reg[15:8];
        db = (s2_cur_reg[7:0] > ref_pix[7:0]) ? s2_cur_reg[7:0] - ref_pix[7:0]
                                              : ref_pix[7:0] - s2_cur_reg[7:0];
        div_prod  = 37'(s4_sum_reg) * 37'(RECIP_1000);
        luma_wide = 9'(div_prod >> DIV_SHIFT);
        grey_wide = s6_scaled_reg[24:8];
    end

    // Pipeline payload from stage 2 on
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s2_cur_reg    <= s1_cur_reg;
            s2_dzero_reg  <= s1_dzero_reg;
            s2_end_reg    <= s1_end_reg;
            s3_pr_reg     <= 17'(dr) * 17'(WEIGHT_RED);
            s3_pg_reg     <= 18'(dg) * 18'(WEIGHT_GREEN);
            s3_pb_reg     <= 15'(db) * 15'(WEIGHT_BLUE);
            s3_end_reg    <= s2_end_reg;
            s4_sum_reg    <= 18'(s3_pr_reg) + s3_pg_reg + 18'(s3_pb_reg);
            s4_end_reg    <= s3_end_reg;
            s5_luma_reg   <= (luma_wide > 9'(GREY_MAX)) ? GREY_MAX : luma_wide[7:0];
            s5_end_reg    <= s4_end_reg;
            s6_scaled_reg <= 25'(s5_luma_reg) * 25'(gain_reg) + 25'(GAIN_ROUND);
            s6_end_reg    <= s5_end_reg;
            grey_reg      <= (grey_wide > 17'(GREY_MAX)) ? GREY_MAX : grey_wide[7:0];
            frame_end_reg <= s6_end_reg;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= in_fire;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign grey      = grey_reg;
    assign frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    // No pixel may be in flight while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !(s1_valid_reg || s2_valid_reg || out_valid_reg))
        else $error("pixel in flight during store clear");

    // A nonzero delay never reads the entry being written
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_dzero_reg) |-> (s1_waddr_reg != s1_raddr_reg))
        else $error("reference read collides with write");

    // Write slot and reference delay stay inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wslot_reg} < (SW+1)'(DELAY_SLOTS)) && ({1'b0, delay_reg} < (SW+1)'(DELAY_SLOTS)))
        else $error("slot index outside ring");

    // A stalled output holds the pipeline tail
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(s6_valid_reg) && $stable(s6_scaled_reg)))
        else $error("pipeline moved under stall");
`endif

endmodule

@@ bench/frame_difference_luma_test.sv @@
// Self-checking testbench for the frame difference luma block.
`timescale 1ns / 100ps

module frame_difference_luma_test;
    import fdl_pkg::*;

    localparam int STORE_SLOTS   = 8;
    localparam int STORE_PIXELS  = 4096;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 40;

    // Register index that decodes to no register
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum int unsigned
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_MOSTLY
    } ready_pattern_t;

    typedef enum int unsigned
    {
        PIX_RANDOM,
        PIX_SCENE,
        PIX_SCENE_NOISY,
        PIX_EXTREME
    } pixel_content_t;

    typedef struct packed
    {
        logic [7:0] grey;
        logic       frame_end;
    } grey_beat_t;

    // Predicts grey output from the pixel history ring and checks the block against it
    class grey_scoreboard;
        logic [23:0]  pixel_history [STORE_SLOTS * STORE_PIXELS];
        int unsigned  slot_now;
        int unsigned  position;
        logic [2:0]   delay_reg;
        logic [16:0]  gain_reg;
        logic [12:0]  frame_len_reg;
        grey_beat_t   expected_grey [$];
        int unsigned  error_count;

        function new();
            foreach (pixel_history[i])
                pixel_history[i] = '0;
            slot_now      = 0;
            position      = 0;
            delay_reg     = 3'd1;
            gain_reg      = GAIN_RESET;
            frame_len_reg = 13'(FRAME_RESET);
            error_count   = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [16:0] value);
            case (index)
                CFG_DELAY_FRAMES: delay_reg     = value[2:0];
                CFG_GAIN_Q8:      gain_reg      = value;
                CFG_FRAME_PIXELS: frame_len_reg = value[12:0];
                default:          ;
            endcase
        endfunction

        function int unsigned channel_gap(logic [7:0] a, logic [7:0] b);
            return (a > b) ? int'(a - b) : int'(b - a);
        endfunction

        // Work out the result of one accepted pixel and advance the ring
        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [23:0]  cur_pix;
            logic [23:0]  past_pix;
            int unsigned  frame_len;
            int unsigned  read_slot;
            int unsigned  luma;
            int unsigned  scaled;
            grey_beat_t   beat;
            cur_pix   = {r, g, b};
            frame_len = 32'(frame_len_reg);
            if (frame_len == 0)
                frame_len = 1;
            if (frame_len > STORE_PIXELS)
                frame_len = STORE_PIXELS;
            read_slot = (slot_now + STORE_SLOTS - delay_reg) % STORE_SLOTS;
            if (delay_reg == 0)
                past_pix = cur_pix;
            else
                past_pix = pixel_history[read_slot * STORE_PIXELS + position];
            pixel_history[slot_now * STORE_PIXELS + position] = cur_pix;

            luma = (channel_gap(r, past_pix[23:16]) * WEIGHT_RED
                  + channel_gap(g, past_pix[15:8]) * WEIGHT_GREEN
                  + channel_gap(b, past_pix[7:0]) * WEIGHT_BLUE) / 1000;
            if (luma > GREY_MAX)
                luma = GREY_MAX;
            scaled = (luma * gain_reg + GAIN_ROUND) >> 8;
            if (scaled > GREY_MAX)
                scaled = GREY_MAX;

            beat.grey = scaled[7:0];
            if (position + 1 >= frame_len)
            begin
                beat.frame_end = 1'b1;
                position       = 0;
                slot_now       = (slot_now + 1) % STORE_SLOTS;
            end
            else
            begin
                beat.frame_end = 1'b0;
                position       = position + 1;
            end
            expected_grey.push_back(beat);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [7:0] grey_seen, logic frame_end_seen);
            grey_beat_t beat;
            if (expected_grey.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result, grey %0d frame_end %0b",
                             $time, grey_seen, frame_end_seen);
                return;
            end
            beat = expected_grey.pop_front();
            if (grey_seen !== beat.grey)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: grey mismatch, expected %0d, actual %0d",
                             $time, beat.grey, grey_seen);
            end
            if (frame_end_seen !== beat.frame_end)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                             $time, beat.frame_end, frame_end_seen);
            end
        endfunction

        function int unsigned pending();
            return expected_grey.size();
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  red        = '0;
    logic [7:0]  green      = '0;
    logic [7:0]  blue       = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  grey;
    logic        frame_end;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = '0;
    logic [16:0] cfg_data   = '0;

    logic        hold_request = 1'b0;
    int unsigned burst_left   = 0;
    logic [23:0] scene [16];

    grey_scoreboard sb;

    frame_difference_luma
    #(
        .DELAY_SLOTS      (STORE_SLOTS),
        .MAX_FRAME_PIXELS (STORE_PIXELS)
    )
    u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grey      (grey),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Note accepted pixels and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_pixel(red, green, blue);
        if (rst_n && out_valid && out_ready)
            sb.check_result(grey, frame_end);
    end

    // Drive out_ready on a changing pattern; hold off for a long stretch on request
    initial
    begin : receiver
        ready_pattern_t pattern;
        int unsigned    span;
        int unsigned    period;
        int unsigned    i;
        logic           held;
        held = 1'b0;
        forever
        begin
            pattern = ready_pattern_t'($urandom_range(0, 3));
            span    = $urandom_range(8, 64);
            period  = $urandom_range(2, 4);
            for (i = 0; i < span; i++)
            begin
                if (hold_request && !held)
                begin
                    out_ready <= 1'b0;
                    held      = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (pattern)
                    READY_ALWAYS:   out_ready <= 1'b1;
                    READY_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                    READY_PERIODIC: out_ready <= (i % period) == 0;
                    default:        out_ready <= $urandom_range(0, 4) != 0;
                endcase
                @(posedge clk);
            end
        end
    end

    // End the run if it stalls
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("frame_difference_luma verification failed");
        $finish;
    end

    // Write one register; leaves the channel idle afterwards
    task automatic write_register(input logic [1:0] index, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel, inserting a random gap between bursts
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic wait_pipeline_empty();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [23:0] make_pixel(pixel_content_t content, int unsigned k,
                                               int unsigned frame_len);
        logic [23:0] base;
        base = scene[(k % frame_len) % 16];
        case (content)
            PIX_SCENE:       return base;
            PIX_SCENE_NOISY: return base ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom),
                                            5'd0, 3'($urandom)};
            PIX_EXTREME:     return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            default:         return 24'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned    random_sent;
        int unsigned    phase_count;
        int unsigned    delay_val;
        int unsigned    gain_val;
        int unsigned    len_val;
        int unsigned    frame_len;
        int unsigned    count;
        int unsigned    k;
        pixel_content_t content;
        logic [23:0]    pix;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first frame compares against black
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        wait_pipeline_empty();

        // Frame length zero acts as one pixel; shortening mid-frame ends it at once
        write_register(CFG_FRAME_PIXELS, 17'd0);
        write_register(CFG_DELAY_FRAMES, 17'd1);
        write_register(CFG_GAIN_Q8, 17'd256);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd128, 8'd64,  8'd32);
        wait_pipeline_empty();

        // Delay zero gives black regardless of gain
        write_register(CFG_DELAY_FRAMES, 17'd0);
        write_register(CFG_GAIN_Q8, 17'd65536);
        send_pixel(8'd200, 8'd10,  8'd90);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd2,   8'd3);
        wait_pipeline_empty();

        // Largest delay with zero gain
        write_register(CFG_DELAY_FRAMES, 17'd7);
        write_register(CFG_GAIN_Q8, 17'd0);
        write_register(CFG_FRAME_PIXELS, 17'd2);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd128, 8'd255);
        send_pixel(8'd77,  8'd0,   8'd200);
        wait_pipeline_empty();

        // Frame length beyond the store saturates; gain at the top of its field
        write_register(CFG_FRAME_PIXELS, 17'd8191);
        write_register(CFG_GAIN_Q8, 17'h1FFFF);
        write_register(CFG_DELAY_FRAMES, 17'd2);
        send_pixel(8'd17,  8'd34,  8'd51);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd9,   8'd9,   8'd9);
        wait_pipeline_empty();

        // Spare index changes nothing; upper data bits are dropped; gain below one
        write_register(CFG_SPARE, 17'h1FFFF);
        write_register(CFG_DELAY_FRAMES, 17'h1FFF9);
        write_register(CFG_FRAME_PIXELS, 17'h1E005);
        write_register(CFG_GAIN_Q8, 17'd128);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd3,   8'd250, 8'd100);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_pipeline_empty();

        // Random phases: new settings, then a run of pixels
        random_sent = 0;
        phase_count = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            delay_val = $urandom_range(0, 7);
            case ($urandom_range(0, 4))
                0:       gain_val = 256;
                1:       gain_val = $urandom_range(0, 131071);
                2:       gain_val = 65536;
                3:       gain_val = $urandom_range(0, 512);
                default: gain_val = $urandom_range(256, 2048);
            endcase
            case ($urandom_range(0, 9))
                0:       len_val = 0;
                1:       len_val = $urandom_range(13, 8191);
                default: len_val = $urandom_range(1, 12);
            endcase
            write_register(CFG_DELAY_FRAMES, 17'(($urandom & 32'h1FFF8) | delay_val));
            write_register(CFG_GAIN_Q8, 17'(gain_val));
            write_register(CFG_FRAME_PIXELS, 17'(($urandom_range(0, 15) << 13) | len_val));

            frame_len = (len_val == 0) ? 1 : (len_val > STORE_PIXELS) ? STORE_PIXELS : len_val;
            if (frame_len > 16)
                count = $urandom_range(10, 30);
            else
                count = frame_len * (delay_val + 2) + $urandom_range(0, 8);
            if (count > 96)
                count = 96;
            if (count < 12)
                count = 12;

            // Hold the receiver off once while the sender keeps going
            if (phase_count == 2)
            begin
                count        = 120;
                hold_request <= 1'b1;
            end

            foreach (scene[i])
                scene[i] = 24'($urandom);
            content = pixel_content_t'($urandom_range(0, 3));
            for (k = 0; k < count; k++)
            begin
                pix = make_pixel(content, k, frame_len);
                send_pixel(pix[23:16], pix[15:8], pix[7:0]);
                random_sent++;
            end
            wait_pipeline_empty();
            phase_count++;
        end

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("frame_difference_luma verification clean");
        else
            $display("frame_difference_luma verification failed");
        $finish;
    end

endmodule
